### rtl/tdfs_pkg.sv
// Shared types and constants for the tank drain and fill sequencer.
`default_nettype none

package tdfs_pkg;

    localparam int LEVEL_W    = 10;
    localparam int TIME_W     = 32;
    localparam int PAUSE_W    = 16;
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;
    localparam int S_DATA_W   = 48;
    localparam int M_DATA_W   = 48;

    typedef enum logic [2:0] {
        PH_IDLE  = 3'd0,
        PH_DRAIN = 3'd1,
        PH_PAUSE = 3'd2,
        PH_FILL  = 3'd3,
        PH_DONE  = 3'd4
    } phase_t;

    typedef enum logic [1:0] {
        KIND_NONE = 2'd0,
        KIND_DIRT = 2'd1,
        KIND_ROT  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        OP_CHECK      = 2'd0,
        OP_START_DIRT = 2'd1,
        OP_START_ROT  = 2'd2,
        OP_CANCEL     = 2'd3
    } op_t;

    localparam logic [CFG_ADDR_W-1:0] CFG_DIRT_DRAIN    = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROT_DRAIN     = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_FILL_LEVEL    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_DIRT_COOLDOWN = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] CFG_ROT_INTERVAL  = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] CFG_PAUSE         = 3'd5;

    localparam logic [LEVEL_W-1:0] RST_DIRT_DRAIN    = 10'd250;
    localparam logic [LEVEL_W-1:0] RST_ROT_DRAIN     = 10'd500;
    localparam logic [LEVEL_W-1:0] RST_FILL_LEVEL    = 10'd1000;
    localparam logic [TIME_W-1:0]  RST_DIRT_COOLDOWN = 32'd3600000;
    localparam logic [TIME_W-1:0]  RST_ROT_INTERVAL  = 32'd7200000;
    localparam logic [PAUSE_W-1:0] RST_PAUSE         = 16'd2000;

endpackage

`default_nettype wire

### rtl/tank_drain_fill_sequencer.sv
// Top level of the tank drain and fill sequencer: input stage, sequencer and result stage.
`default_nettype none

// Each input transaction (periodic check, manual start, or cancel) yields exactly one
// result transaction showing pump drive, phase, kind and the last exchange record
// after that request. The block takes one transaction per cycle while the output is
// not stalled: a transaction is captured in an input register, the sequencer state and
// the result are computed from it and updated when it advances, and the result waits
// in an output register that drives m_tvalid and m_tdata. Configuration writes must
// be made while no transaction is in flight.
module tank_drain_fill_sequencer import tdfs_pkg::*; (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_ADDR_W-1:0] cfg_addr,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    // From bit 0: level[9:0], dirt_seen[10], now_ms[42:11], zero fill.
    input  wire logic [S_DATA_W-1:0]   s_tdata,
    // operation[1:0].
    input  wire logic [1:0]            s_tuser,
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    // From bit 0: drain_pump[0], fill_pump[1], phase[4:2], kind[6:5], in_progress[7],
    // accepted[8], last_success[9], last_duration_ms[41:10], zero fill.
    output logic [M_DATA_W-1:0]        m_tdata
);

    // Configuration registers.
    logic [LEVEL_W-1:0] dirt_drain_reg;
    logic [LEVEL_W-1:0] rot_drain_reg;
    logic [LEVEL_W-1:0] fill_level_reg;
    logic [TIME_W-1:0]  dirt_cooldown_reg;
    logic [TIME_W-1:0]  rot_interval_reg;
    logic [PAUSE_W-1:0] pause_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dirt_drain_reg    <= RST_DIRT_DRAIN;
            rot_drain_reg     <= RST_ROT_DRAIN;
            fill_level_reg    <= RST_FILL_LEVEL;
            dirt_cooldown_reg <= RST_DIRT_COOLDOWN;
            rot_interval_reg  <= RST_ROT_INTERVAL;
            pause_reg         <= RST_PAUSE;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_DIRT_DRAIN:    dirt_drain_reg    <= cfg_wdata[LEVEL_W-1:0];
                CFG_ROT_DRAIN:     rot_drain_reg     <= cfg_wdata[LEVEL_W-1:0];
                CFG_FILL_LEVEL:    fill_level_reg    <= cfg_wdata[LEVEL_W-1:0];
                CFG_DIRT_COOLDOWN: dirt_cooldown_reg <= cfg_wdata[TIME_W-1:0];
                CFG_ROT_INTERVAL:  rot_interval_reg  <= cfg_wdata[TIME_W-1:0];
                CFG_PAUSE:         pause_reg         <= cfg_wdata[PAUSE_W-1:0];
                default: ;
            endcase
        end
    end

    // Input stage.
    logic               in_valid_reg;
    op_t                in_op_reg;
    logic [LEVEL_W-1:0] in_level_reg;
    logic               in_dirt_reg;
    logic [TIME_W-1:0]  in_now_reg;
    logic               advance;

    assign advance  = in_valid_reg && (!m_tvalid || m_tready);
    assign s_tready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_tready) begin
            in_valid_reg <= s_tvalid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tvalid && s_tready) begin
            in_op_reg    <= op_t'(s_tuser);
            in_level_reg <= s_tdata[LEVEL_W-1:0];
            in_dirt_reg  <= s_tdata[LEVEL_W];
            in_now_reg   <= s_tdata[LEVEL_W+1 +: TIME_W];
        end
    end

    // Sequencer state.
    phase_t             phase_reg, phase_next;
    kind_t              kind_reg, kind_next;
    logic [LEVEL_W-1:0] drain_target_reg, drain_target_next;
    logic [TIME_W-1:0]  start_time_reg, start_time_next;
    logic [TIME_W-1:0]  pause_start_reg, pause_start_next;
    logic [TIME_W-1:0]  last_dirt_reg, last_dirt_next;
    logic [TIME_W-1:0]  last_rot_reg, last_rot_next;
    logic [TIME_W-1:0]  duration_reg, duration_next;
    logic               success_reg, success_next;
    logic               drain_pump_reg, drain_pump_next;
    logic               fill_pump_reg, fill_pump_next;
    logic               accepted_next;

    logic [TIME_W-1:0] dirt_elapsed;
    logic [TIME_W-1:0] rot_elapsed;
    logic [TIME_W-1:0] pause_elapsed;
    logic              dirt_cooled;
    logic              start_req;
    logic              start_now;
    kind_t             start_kind;

    assign dirt_elapsed  = in_now_reg - last_dirt_reg;
    assign rot_elapsed   = in_now_reg - last_rot_reg;
    assign pause_elapsed = in_now_reg - pause_start_reg;
    // A last dirt time of zero means no dirt exchange has happened yet.
    assign dirt_cooled   = (last_dirt_reg == '0) || (dirt_elapsed >= dirt_cooldown_reg);

    // Decide whether this transaction starts an exchange, and of which kind.
    always_comb begin
        start_req  = 1'b0;
        start_kind = KIND_DIRT;
        case (in_op_reg)
            OP_CHECK: begin
                if (phase_reg == PH_IDLE) begin
                    if (dirt_cooled && in_dirt_reg) begin
                        start_req  = 1'b1;
                        start_kind = KIND_DIRT;
                    end else if (rot_elapsed >= rot_interval_reg) begin
                        start_req  = 1'b1;
                        start_kind = KIND_ROT;
                    end
                end
            end
            OP_START_DIRT: begin
                start_req  = (phase_reg == PH_IDLE);
                start_kind = KIND_DIRT;
            end
            OP_START_ROT: begin
                start_req  = (phase_reg == PH_IDLE);
                start_kind = KIND_ROT;
            end
            default: ;
        endcase
    end

    assign start_now = start_req && advance;

    // Next state.
    always_comb begin
        phase_next        = phase_reg;
        kind_next         = kind_reg;
        drain_target_next = drain_target_reg;
        start_time_next   = start_time_reg;
        pause_start_next  = pause_start_reg;
        last_dirt_next    = last_dirt_reg;
        last_rot_next     = last_rot_reg;
        duration_next     = duration_reg;
        success_next      = success_reg;
        drain_pump_next   = drain_pump_reg;
        fill_pump_next    = fill_pump_reg;
        accepted_next     = 1'b0;

        if (start_req) begin
            phase_next        = PH_DRAIN;
            kind_next         = start_kind;
            drain_target_next = (start_kind == KIND_DIRT) ? dirt_drain_reg : rot_drain_reg;
            start_time_next   = in_now_reg;
            success_next      = 1'b0;
            drain_pump_next   = 1'b1;
            fill_pump_next    = 1'b0;
            if (start_kind == KIND_DIRT) begin
                last_dirt_next = in_now_reg;
            end else begin
                last_rot_next = in_now_reg;
            end
            accepted_next = (in_op_reg != OP_CHECK);
        end else if (in_op_reg == OP_CANCEL) begin
            if (phase_reg != PH_IDLE) begin
                phase_next      = PH_IDLE;
                kind_next       = KIND_NONE;
                success_next    = 1'b0;
                drain_pump_next = 1'b0;
                fill_pump_next  = 1'b0;
                accepted_next   = 1'b1;
            end
        end else if (in_op_reg == OP_CHECK) begin
            case (phase_reg)
                PH_IDLE: ;
                PH_DRAIN: begin
                    if (in_level_reg <= drain_target_reg) begin
                        drain_pump_next  = 1'b0;
                        pause_start_next = in_now_reg;
                        phase_next       = PH_PAUSE;
                    end
                end
                PH_PAUSE: begin
                    if (pause_elapsed >= {{(TIME_W-PAUSE_W){1'b0}}, pause_reg}) begin
                        fill_pump_next = 1'b1;
                        phase_next     = PH_FILL;
                    end
                end
                PH_FILL: begin
                    if (in_level_reg >= fill_level_reg) begin
                        fill_pump_next = 1'b0;
                        phase_next     = PH_DONE;
                    end
                end
                default: begin
                    duration_next = in_now_reg - start_time_reg;
                    success_next  = 1'b1;
                    phase_next    = PH_IDLE;
                    kind_next     = KIND_NONE;
                end
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg        <= PH_IDLE;
            kind_reg         <= KIND_NONE;
            drain_target_reg <= '0;
            start_time_reg   <= '0;
            pause_start_reg  <= '0;
            last_dirt_reg    <= '0;
            last_rot_reg     <= '0;
            duration_reg     <= '0;
            success_reg      <= 1'b0;
            drain_pump_reg   <= 1'b0;
            fill_pump_reg    <= 1'b0;
        end else if (advance) begin
            phase_reg        <= phase_next;
            kind_reg         <= kind_next;
            drain_target_reg <= drain_target_next;
            start_time_reg   <= start_time_next;
            pause_start_reg  <= pause_start_next;
            last_dirt_reg    <= last_dirt_next;
            last_rot_reg     <= last_rot_next;
            duration_reg     <= duration_next;
            success_reg      <= success_next;
            drain_pump_reg   <= drain_pump_next;
            fill_pump_reg    <= fill_pump_next;
        end
    end

    // Result word, built from the state after this transaction.
    logic [M_DATA_W-1:0] result_word;
    logic                in_progress_next;

    always_comb begin
        in_progress_next = (phase_next == PH_DRAIN) || (phase_next == PH_PAUSE)
                           || (phase_next == PH_FILL);
        result_word = {
            {(M_DATA_W-42){1'b0}},
            duration_next,
            success_next,
            accepted_next,
            in_progress_next,
            kind_next,
            phase_next,
            fill_pump_next,
            drain_pump_next
        };
    end

    // Output stage.
    logic                out_valid_reg;
    logic [M_DATA_W-1:0] out_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (!m_tvalid || m_tready) begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (advance) begin
            out_data_reg <= result_word;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_data_reg;

    // The pumps follow the phase: drain only while draining, fill only while filling.
    a_pumps_match_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[0] == (m_tdata[4:2] == PH_DRAIN))
                  && (m_tdata[1] == (m_tdata[4:2] == PH_FILL)))
        else $error("pump drive does not match phase");

    // An exchange in progress always has a kind, and idle never does.
    a_kind_matches_phase: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[7] == (m_tdata[6:5] != KIND_NONE))
                  || (m_tdata[4:2] == PH_DONE))
        else $error("kind inconsistent with phase");

    // A periodic check never reports an accepted request.
    a_check_not_accepted: assert property (@(posedge aclk) disable iff (!aresetn)
        (advance && in_op_reg == OP_CHECK) |=> !m_tdata[8])
        else $error("periodic check reported as accepted");

    // A start leaves the sequencer draining with the drain pump on.
    a_start_drains: assert property (@(posedge aclk) disable iff (!aresetn)
        start_now |=> (phase_reg == PH_DRAIN) && drain_pump_reg && !success_reg)
        else $error("start did not enter the draining phase");

endmodule

`default_nettype wire

### test/tank_drain_fill_sequencer_tb.sv
// Self-checking testbench for the tank drain and fill sequencer, with a built-in predictor.
module tank_drain_fill_sequencer_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tdfs_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int PHASE_ITEMS = 110;
    localparam int MAX_PRINTS  = 40;
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED = 3'd7;

    typedef struct {
        op_t             op;
        logic [9:0]      level;
        logic            dirt;
        logic [31:0]     now_ms;
        bit              wait_for_idle;
    } request_t;

    typedef struct {
        logic            drain_pump;
        logic            fill_pump;
        phase_t          phase;
        kind_t           kind;
        logic            in_progress;
        logic            accepted;
        logic            last_success;
        logic [31:0]     duration;
    } status_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    logic [CFG_ADDR_W-1:0] cfg_addr = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_DATA_W-1:0]   s_tdata = '0;
    logic [1:0]            s_tuser = OP_CHECK;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_DATA_W-1:0]   m_tdata;

    tank_drain_fill_sequencer DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

    always #2 aclk = ~aclk;

    // Shadow copy of the configuration registers.
    logic [9:0]  cfg_dirt_level = RST_DIRT_DRAIN;
    logic [9:0]  cfg_rot_level  = RST_ROT_DRAIN;
    logic [9:0]  cfg_fill_level = RST_FILL_LEVEL;
    logic [31:0] cfg_cooldown   = RST_DIRT_COOLDOWN;
    logic [31:0] cfg_interval   = RST_ROT_INTERVAL;
    logic [15:0] cfg_pause      = RST_PAUSE;

    // Predicted sequencer state.
    phase_t      ex_phase = PH_IDLE;
    kind_t       ex_kind = KIND_NONE;
    logic [9:0]  ex_target = '0;
    logic [31:0] ex_start = '0;
    logic [31:0] ex_pause_start = '0;
    logic [31:0] ex_last_dirt = '0;
    logic [31:0] ex_last_rot = '0;
    logic [31:0] ex_duration = '0;
    logic        ex_success = 1'b0;
    logic        ex_drain_on = 1'b0;
    logic        ex_fill_on = 1'b0;

    request_t    request_q[$];
    status_t     status_q[$];
    int          error_count = 0;
    int          cycle_count = 0;
    logic [31:0] gen_now = '0;
    bit          gate_next = 1'b0;

    function automatic void open_exchange(kind_t which, logic [31:0] at);
        ex_kind = which;
        ex_phase = PH_DRAIN;
        ex_target = (which == KIND_DIRT) ? cfg_dirt_level : cfg_rot_level;
        ex_start = at;
        ex_success = 1'b0;
        ex_drain_on = 1'b1;
        ex_fill_on = 1'b0;
        if (which == KIND_DIRT) begin
            ex_last_dirt = at;
        end else begin
            ex_last_rot = at;
        end
    endfunction

    function automatic status_t step_exchange(request_t req);
        status_t     res;
        logic        acc;
        logic        cooled;
        logic [31:0] elapsed;
        acc = 1'b0;
        case (req.op)
            OP_CHECK: begin
                case (ex_phase)
                    PH_IDLE: begin
                        elapsed = req.now_ms - ex_last_dirt;
                        cooled = (ex_last_dirt == 32'd0) || (elapsed >= cfg_cooldown);
                        elapsed = req.now_ms - ex_last_rot;
                        if (cooled && req.dirt) begin
                            open_exchange(KIND_DIRT, req.now_ms);
                        end else if (elapsed >= cfg_interval) begin
                            open_exchange(KIND_ROT, req.now_ms);
                        end
                    end
                    PH_DRAIN: begin
                        if (req.level <= ex_target) begin
                            ex_drain_on = 1'b0;
                            ex_pause_start = req.now_ms;
                            ex_phase = PH_PAUSE;
                        end
                    end
                    PH_PAUSE: begin
                        elapsed = req.now_ms - ex_pause_start;
                        if (elapsed >= {16'd0, cfg_pause}) begin
                            ex_fill_on = 1'b1;
                            ex_phase = PH_FILL;
                        end
                    end
                    PH_FILL: begin
                        if (req.level >= cfg_fill_level) begin
                            ex_fill_on = 1'b0;
                            ex_phase = PH_DONE;
                        end
                    end
                    default: begin
                        ex_duration = req.now_ms - ex_start;
                        ex_success = 1'b1;
                        ex_phase = PH_IDLE;
                        ex_kind = KIND_NONE;
                    end
                endcase
            end
            OP_START_DIRT, OP_START_ROT: begin
                if (ex_phase == PH_IDLE) begin
                    open_exchange((req.op == OP_START_DIRT) ? KIND_DIRT : KIND_ROT, req.now_ms);
                    acc = 1'b1;
                end
            end
            default: begin
                if (ex_phase != PH_IDLE) begin
                    ex_drain_on = 1'b0;
                    ex_fill_on = 1'b0;
                    ex_phase = PH_IDLE;
                    ex_kind = KIND_NONE;
                    ex_success = 1'b0;
                    acc = 1'b1;
                end
            end
        endcase
        res.drain_pump = ex_drain_on;
        res.fill_pump = ex_fill_on;
        res.phase = ex_phase;
        res.kind = ex_kind;
        res.in_progress = (ex_phase == PH_DRAIN) || (ex_phase == PH_PAUSE)
                          || (ex_phase == PH_FILL);
        res.accepted = acc;
        res.last_success = ex_success;
        res.duration = ex_duration;
        return res;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        if (error_count < MAX_PRINTS) begin
            $display("%0t ns: mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        end
        error_count++;
    endtask

    task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
        if (got !== want) begin
            report_mismatch(what, got, want);
        end
    endtask

    task automatic write_reg(logic [CFG_ADDR_W-1:0] idx, logic [31:0] value);
        @(posedge aclk);
        cfg_we <= 1'b1;
        cfg_addr <= idx;
        cfg_wdata <= value;
        @(posedge aclk);
        cfg_we <= 1'b0;
        case (idx)
            CFG_DIRT_DRAIN:    cfg_dirt_level = value[9:0];
            CFG_ROT_DRAIN:     cfg_rot_level = value[9:0];
            CFG_FILL_LEVEL:    cfg_fill_level = value[9:0];
            CFG_DIRT_COOLDOWN: cfg_cooldown = value;
            CFG_ROT_INTERVAL:  cfg_interval = value;
            CFG_PAUSE:         cfg_pause = value[15:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [31:0] dirt_lvl, logic [31:0] rot_lvl,
                                  logic [31:0] fill_lvl, logic [31:0] cooldown,
                                  logic [31:0] interval, logic [31:0] pause);
        write_reg(CFG_DIRT_DRAIN, dirt_lvl);
        write_reg(CFG_ROT_DRAIN, rot_lvl);
        write_reg(CFG_FILL_LEVEL, fill_lvl);
        write_reg(CFG_DIRT_COOLDOWN, cooldown);
        write_reg(CFG_ROT_INTERVAL, interval);
        write_reg(CFG_PAUSE, pause);
        @(negedge aclk);
    endtask

    // Waits until every request has gone through and its status has come back.
    task automatic settle();
        while (request_q.size() != 0 || status_q.size() != 0) begin
            @(posedge aclk);
        end
        repeat (4) @(posedge aclk);
    endtask

    task automatic push_req(op_t op, logic [9:0] level, logic dirt, logic [31:0] now_ms);
        request_t req;
        req.op = op;
        req.level = level;
        req.dirt = dirt;
        req.now_ms = now_ms;
        req.wait_for_idle = gate_next;
        gate_next = 1'b0;
        request_q.push_back(req);
    endtask

    function automatic logic [31:0] tick(int unsigned max_step);
        gen_now += $urandom_range(0, max_step);
        return gen_now;
    endfunction

    // A stray start or cancel dropped into the middle of an exchange now and then.
    task automatic maybe_disrupt();
        if ($urandom_range(0, 99) < 8) begin
            push_req(op_t'($urandom_range(1, 3)), 10'($urandom_range(0, 1023)),
                     1'($urandom_range(0, 1)), tick(40));
        end
    endtask

    // Mostly complete exchanges with random content, the rest random requests.
    task automatic queue_water_changes(int count);
        int          target_end;
        bit          dirt_kind;
        logic [9:0]  target;
        logic [31:0] t0;
        logic [31:0] stamp;
        target_end = request_q.size() + count;
        while (request_q.size() < target_end) begin
            if ($urandom_range(0, 99) < 75) begin
                dirt_kind = 1'($urandom_range(0, 1));
                target = dirt_kind ? cfg_dirt_level : cfg_rot_level;
                if ($urandom_range(0, 1) != 0) begin
                    push_req(dirt_kind ? OP_START_DIRT : OP_START_ROT,
                             10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)), tick(40));
                end else begin
                    gen_now += (dirt_kind ? cfg_cooldown : cfg_interval);
                    push_req(OP_CHECK, 10'($urandom_range(0, 1023)), dirt_kind, tick(20));
                end
                repeat ($urandom_range(0, 3)) begin
                    push_req(OP_CHECK, (target >= 10'd1023) ? target
                             : 10'($urandom_range(target + 1, 1023)),
                             1'($urandom_range(0, 1)), tick(40));
                end
                maybe_disrupt();
                push_req(OP_CHECK, 10'($urandom_range(0, target)), 1'($urandom_range(0, 1)),
                         tick(40));
                t0 = gen_now;
                repeat ($urandom_range(0, 2)) begin
                    push_req(OP_CHECK, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                             tick(32'(cfg_pause >> 1)));
                end
                maybe_disrupt();
                gen_now = t0 + 32'(cfg_pause) + $urandom_range(0, 5);
                push_req(OP_CHECK, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                         gen_now);
                repeat ($urandom_range(0, 3)) begin
                    push_req(OP_CHECK, (cfg_fill_level == 10'd0) ? 10'd0
                             : 10'($urandom_range(0, cfg_fill_level - 1)),
                             1'($urandom_range(0, 1)), tick(40));
                end
                maybe_disrupt();
                push_req(OP_CHECK, 10'($urandom_range(cfg_fill_level, 1023)),
                         1'($urandom_range(0, 1)), tick(40));
                push_req(OP_CHECK, 10'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)),
                         tick(500));
            end else begin
                if ($urandom_range(0, 9) == 0) begin
                    gen_now = $urandom;
                    stamp = gen_now;
                end else begin
                    stamp = tick(100);
                end
                push_req(op_t'($urandom_range(0, 3)), 10'($urandom_range(0, 1023)),
                         1'($urandom_range(0, 1)), stamp);
            end
        end
    endtask

    task automatic run_phase();
        queue_water_changes(PHASE_ITEMS);
        gate_next = 1'b1;
        queue_water_changes(PHASE_ITEMS);
        settle();
    endtask

    // Sender: bursts of random length separated by random gaps.
    int burst_left = 0;
    int gap_left = 0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
            s_tdata <= '0;
            s_tuser <= OP_CHECK;
        end else begin
            if (s_tvalid && s_tready) begin
                status_q.push_back(step_exchange(request_q.pop_front()));
            end
            if (!(s_tvalid && !s_tready)) begin
                if (gap_left > 0) begin
                    gap_left--;
                    s_tvalid <= 1'b0;
                end else if (request_q.size() == 0
                             || (request_q[0].wait_for_idle && status_q.size() != 0)) begin
                    s_tvalid <= 1'b0;
                end else begin
                    s_tvalid <= 1'b1;
                    s_tdata <= {5'd0, request_q[0].now_ms, request_q[0].dirt,
                                request_q[0].level};
                    s_tuser <= request_q[0].op;
                    if (burst_left > 0) begin
                        burst_left--;
                    end else begin
                        burst_left = $urandom_range(1, 40);
                        gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                    end
                end
            end
        end
    end

    // Receiver: switches between stall patterns, plus one long hold-off.
    int          seen_results = 0;
    int          hold_left = 0;
    bit          held_once = 1'b0;
    int          stall_mode = 0;
    int          mode_left = 0;
    logic [1:0]  stall_tick = '0;

    always @(posedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                seen_results++;
            end
            stall_tick++;
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else if (!held_once && seen_results >= 300) begin
                held_once = 1'b1;
                hold_left = 400;
                m_tready <= 1'b0;
            end else begin
                if (mode_left == 0) begin
                    stall_mode = $urandom_range(0, 2);
                    mode_left = $urandom_range(20, 120);
                end else begin
                    mode_left--;
                end
                case (stall_mode)
                    0:       m_tready <= 1'b1;
                    1:       m_tready <= 1'($urandom_range(0, 1));
                    default: m_tready <= (stall_tick == 2'b00);
                endcase
            end
        end
    end

    always @(posedge aclk) begin : result_check
        status_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (status_q.size() == 0) begin
                report_mismatch("unexpected result transaction", m_tdata[31:0], '0);
            end else begin
                want = status_q.pop_front();
                check_field("drain_pump", 32'(m_tdata[0]), 32'(want.drain_pump));
                check_field("fill_pump", 32'(m_tdata[1]), 32'(want.fill_pump));
                check_field("phase", 32'(m_tdata[4:2]), 32'(want.phase));
                check_field("kind", 32'(m_tdata[6:5]), 32'(want.kind));
                check_field("in_progress", 32'(m_tdata[7]), 32'(want.in_progress));
                check_field("accepted", 32'(m_tdata[8]), 32'(want.accepted));
                check_field("last_success", 32'(m_tdata[9]), 32'(want.last_success));
                check_field("last_duration_ms", m_tdata[41:10], want.duration);
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // Directed part with the reset settings.
        push_req(OP_CANCEL, 10'd500, 1'b0, 32'd0);
        // A dirt exchange at time zero leaves the last dirt time reading as never.
        push_req(OP_CHECK, 10'd600, 1'b1, 32'd0);
        push_req(OP_START_ROT, 10'd600, 1'b0, 32'd10);
        push_req(OP_CHECK, 10'd1023, 1'b0, 32'd20);
        push_req(OP_CHECK, 10'd250, 1'b0, 32'd100);
        push_req(OP_CHECK, 10'd0, 1'b1, 32'd2099);
        push_req(OP_CHECK, 10'd0, 1'b0, 32'd2100);
        push_req(OP_CHECK, 10'd999, 1'b0, 32'd2200);
        push_req(OP_CHECK, 10'd1000, 1'b0, 32'd2300);
        push_req(OP_START_DIRT, 10'd1000, 1'b0, 32'd2400);
        push_req(OP_CHECK, 10'd1000, 1'b0, 32'd5000);
        push_req(OP_CHECK, 10'd700, 1'b1, 32'd6000);
        push_req(OP_CANCEL, 10'd700, 1'b0, 32'd6100);
        push_req(OP_CANCEL, 10'd700, 1'b0, 32'd6200);
        push_req(OP_CHECK, 10'd700, 1'b1, 32'd7000);
        push_req(OP_START_ROT, 10'd700, 1'b0, 32'd8000);
        push_req(OP_CHECK, 10'd0, 1'b0, 32'd8100);
        push_req(OP_CANCEL, 10'd0, 1'b0, 32'd8200);
        push_req(OP_START_DIRT, 10'd800, 1'b1, 32'd9000);
        push_req(OP_CANCEL, 10'd800, 1'b0, 32'd9100);
        // The pause starts just before the time counter wraps.
        push_req(OP_CHECK, 10'd800, 1'b0, 32'hFFFF_FFFF);
        push_req(OP_CHECK, 10'd0, 1'b0, 32'hFFFF_FFFF);
        push_req(OP_CHECK, 10'd0, 1'b0, 32'd1000);
        push_req(OP_CHECK, 10'd0, 1'b0, 32'd1999);
        push_req(OP_CHECK, 10'd1023, 1'b0, 32'd2000);
        push_req(OP_CANCEL, 10'd1023, 1'b0, 32'd2100);
        gen_now = 32'd3000;
        settle();

        apply_settings($urandom_range(0, 1000), $urandom_range(0, 1000),
                       $urandom_range(0, 1000), $urandom_range(0, 5000),
                       $urandom_range(0, 20000), $urandom_range(0, 3000));
        run_phase();

        apply_settings(32'd0, 32'd0, 32'd0, 32'd0, 32'd0, 32'd0);
        run_phase();

        apply_settings(32'd1000, 32'd1000, 32'd1000, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'd65535);
        run_phase();

        // Upper bits of the narrow registers must be dropped; the spare index is ignored.
        write_reg(CFG_UNUSED, $urandom);
        apply_settings(($urandom & 32'hFFFF_FC00) | $urandom_range(0, 1000),
                       ($urandom & 32'hFFFF_FC00) | $urandom_range(0, 1000),
                       ($urandom & 32'hFFFF_FC00) | $urandom_range(500, 1000),
                       $urandom_range(0, 50000), $urandom_range(0, 50000),
                       ($urandom & 32'hFFFF_0000) | $urandom_range(0, 2000));
        run_phase();

        apply_settings(32'(RST_DIRT_DRAIN), 32'(RST_ROT_DRAIN), 32'(RST_FILL_LEVEL),
                       RST_DIRT_COOLDOWN, RST_ROT_INTERVAL, 32'(RST_PAUSE));
        run_phase();

        apply_settings($urandom_range(0, 1000), $urandom_range(0, 1000),
                       $urandom_range(500, 1000), $urandom_range(0, 100000),
                       $urandom_range(0, 100000), $urandom_range(0, 500));
        run_phase();

        apply_settings($urandom_range(0, 1000), $urandom_range(0, 1000), 32'd1000, 32'd0,
                       32'hFFFF_FFFF, $urandom_range(0, 65535));
        run_phase();

        repeat (10) @(posedge aclk);
        if (error_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
